// ===== hw/rtl/lcsb_pkg.sv =====
// ----------------------------------------------------------------------------
// LED column scroll buffer package
// Field widths, command and status codes, and the command word that the
// controller broadcasts to the column cells.
// ----------------------------------------------------------------------------
`default_nettype none

package lcsb_pkg;

    localparam int MAX_COLUMNS_DEFAULT = 256;
    localparam int ROWS                = 8;
    localparam int ROW_IDX_W           = $clog2(ROWS);

    localparam int OPERATION_W     = 3;
    localparam int COLUMN_W        = 8;
    localparam int ROW_W           = 4;
    localparam int PIXEL_ON_W      = 1;
    localparam int DIRECTION_W     = 2;
    localparam int STEP_COUNT_W    = 16;
    localparam int WIDTH_REQUEST_W = 9;

    localparam int PIXEL_VALUE_W   = 1;
    localparam int VISIBLE_WIDTH_W = 9;
    localparam int STATUS_W        = 2;

    localparam int COLUMN_LSB        = 0;
    localparam int ROW_LSB           = COLUMN_LSB + COLUMN_W;
    localparam int PIXEL_ON_LSB      = ROW_LSB + ROW_W;
    localparam int DIRECTION_LSB     = PIXEL_ON_LSB + PIXEL_ON_W;
    localparam int STEP_COUNT_LSB    = DIRECTION_LSB + DIRECTION_W;
    localparam int WIDTH_REQUEST_LSB = STEP_COUNT_LSB + STEP_COUNT_W;
    localparam int S_FIELDS_W        = WIDTH_REQUEST_LSB + WIDTH_REQUEST_W;
    localparam int S_TDATA_W         = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W         = OPERATION_W;

    localparam int M_FIELDS_W = PIXEL_VALUE_W + VISIBLE_WIDTH_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = STATUS_W;

    typedef enum logic [OPERATION_W-1:0] {
        OP_SET_PIXEL = 3'd0,
        OP_GET_PIXEL = 3'd1,
        OP_SET_WIDTH = 3'd2,
        OP_CLEAR     = 3'd3,
        OP_RESET     = 3'd4,
        OP_ROTATE    = 3'd5,
        OP_SHIFT     = 3'd6
    } op_t;

    typedef enum logic [DIRECTION_W-1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_ROW_RANGE = 2'd1,
        STAT_CAPACITY  = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        CELL_HOLD      = 4'd0,
        CELL_WRITE     = 4'd1,
        CELL_CLEAR     = 4'd2,
        CELL_UP        = 4'd3,
        CELL_DOWN      = 4'd4,
        CELL_ROTL      = 4'd5,
        CELL_INSR      = 4'd6,
        CELL_LOAD      = 4'd7,
        CELL_SHIFT_OUT = 4'd8
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [ROW_IDX_W-1:0]   row;
        logic                   pixel_on;
        logic [ROW_IDX_W-1:0]   amount;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lcsb_cell.sv =====
// ----------------------------------------------------------------------------
// LED column scroll buffer column cell
// Holds one stored column and one bit of the read-out chain, and acts on the
// command word broadcast to the whole row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsb_cell
    import lcsb_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int IDX_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cell_cmd_t         cmd,
    input  wire logic [IDX_W-1:0]  pos,
    input  wire logic [IDX_W-1:0]  last_idx,
    input  wire logic [ROWS-1:0]   next_col,
    input  wire logic [ROWS-1:0]   prev_col,
    input  wire logic [ROWS-1:0]   head_col,
    input  wire logic              read_in,
    output logic      [ROWS-1:0]   col,
    output logic                   read_bit
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [ROWS-1:0] col_reg, col_next;
    logic            read_reg, read_next;

    always_comb begin
        col_next  = col_reg;
        read_next = read_reg;
        case (cmd.op)
            CELL_WRITE: begin
                if (pos == MY_IDX) begin
                    col_next[cmd.row] = cmd.pixel_on;
                end
            end
            CELL_CLEAR:     col_next = '0;
            CELL_UP:        col_next = col_reg << cmd.amount;
            CELL_DOWN:      col_next = col_reg >> cmd.amount;
            CELL_ROTL: begin
                if (MY_IDX == last_idx) begin
                    col_next = head_col;
                end else if (MY_IDX < last_idx) begin
                    col_next = next_col;
                end
            end
            CELL_INSR:      col_next  = prev_col;
            CELL_LOAD:      read_next = col_reg[cmd.row];
            CELL_SHIFT_OUT: read_next = read_in;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else begin
            col_reg <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        read_reg <= read_next;
    end

    assign col      = col_reg;
    assign read_bit = read_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lcsb_rem.sv =====
// ----------------------------------------------------------------------------
// LED column scroll buffer remainder unit
// Restoring division that produces the remainder one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsb_rem
    import lcsb_pkg::*;
#(
    parameter int DVD_W = STEP_COUNT_W,
    parameter int DVS_W = 9
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DVD_W-1:0]  dividend,
    input  wire logic [DVS_W-1:0]  divisor,
    output logic                   done,
    output logic      [DVS_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = (trial >= {1'b0, dvs_reg}) ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/led_column_scroll_buffer_top.sv =====
// ----------------------------------------------------------------------------
// LED column scroll buffer
// Frame store for an eight-row LED matrix built as a row of column cells,
// with a command sequencer, a remainder unit and a registered result stage.
// ----------------------------------------------------------------------------
// Pixel writes, width, clear, reset, row shifts and origin moves pass through
// the execute and done states; the next command is taken in the done state
// once the output is free. Get pixel inside the store loads the read-out
// chain and shifts the bit to cell zero. Column rotation: the remainder unit
// takes the step count modulo the width, then one column step per cycle; a
// shift right inserts columns. Synchronous reset clears every cell at once.
`default_nettype none

module led_column_scroll_buffer_top
    import lcsb_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // column, row, pixel_on, direction, step_count, width_request
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // operation
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // pixel_value, visible_width, zero padding
    output logic      [M_TDATA_W-1:0]  m_tdata,
    // status
    output logic      [M_TUSER_W-1:0]  m_tuser
);

    localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int IDX_W  = $clog2(MAX_COLUMNS);
    localparam int SUM_W  = ((CNT_W > WIDTH_REQUEST_W) ? CNT_W : WIDTH_REQUEST_W) + 1;
    localparam int WIDE_W = ((CNT_W > STEP_COUNT_W) ? CNT_W : STEP_COUNT_W) + 1;
    localparam logic [SUM_W-1:0]  MAX_SUM  = SUM_W'(MAX_COLUMNS);
    localparam logic [WIDE_W-1:0] MAX_WIDE = WIDE_W'(MAX_COLUMNS);
    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_COLUMNS);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_EXEC = 7'b0000010,
        ST_READ = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_ROT  = 7'b0010000,
        ST_INS  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [CNT_W-1:0]             total_reg, total_next;
    logic [CNT_W-1:0]             origin_reg, origin_next;
    logic [IDX_W-1:0]             cnt_reg, cnt_next;
    logic                         pix_reg, pix_next;
    status_t                      status_reg, status_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic                         pix_out_reg, pix_out_next;
    logic [VISIBLE_WIDTH_W-1:0]   vis_out_reg, vis_out_next;
    status_t                      stat_out_reg, stat_out_next;

    op_t                          op_reg;
    logic [COLUMN_W-1:0]          col_in_reg;
    logic [ROW_W-1:0]             row_in_reg;
    logic                         on_reg;
    dir_t                         dir_reg;
    logic [STEP_COUNT_W-1:0]      steps_reg;
    logic [WIDTH_REQUEST_W-1:0]   wreq_reg;

    logic                         accept;
    logic                         out_free;
    logic [SUM_W-1:0]             pix_pos;
    logic [SUM_W-1:0]             wreq_pos;
    logic [WIDE_W-1:0]            steps_w, origin_w, total_w, ins_w, left_sum;
    logic [CNT_W-1:0]             last_w;
    logic [CNT_W-1:0]             vis_full;
    logic [CNT_W-1:0]             rot_cnt;
    logic                         row_bad;

    cell_cmd_t                    cell_cmd;
    logic [ROWS-1:0]              col_data [MAX_COLUMNS];
    logic                         read_bits [MAX_COLUMNS];

    logic                         rem_start;
    logic                         rem_done;
    logic [CNT_W-1:0]             rem_value;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free);
    assign accept   = s_tvalid && s_tready;

    assign pix_pos  = SUM_W'(col_in_reg) + SUM_W'(origin_reg);
    assign wreq_pos = SUM_W'(wreq_reg) + SUM_W'(origin_reg);
    assign steps_w  = WIDE_W'(steps_reg);
    assign origin_w = WIDE_W'(origin_reg);
    assign total_w  = WIDE_W'(total_reg);
    assign ins_w    = steps_w - origin_w;
    assign left_sum = origin_w + steps_w;
    assign last_w   = total_reg - CNT_W'(1);
    assign vis_full = total_reg - origin_reg;
    assign row_bad  = row_in_reg >= ROW_W'(ROWS);
    assign rot_cnt  = ((dir_reg == DIR_RIGHT) && (rem_value != '0)) ? (total_reg - rem_value)
                                                                    : rem_value;

    always_comb begin
        state_next    = state_reg;
        total_next    = total_reg;
        origin_next   = origin_reg;
        cnt_next      = cnt_reg;
        pix_next      = pix_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        pix_out_next  = pix_out_reg;
        vis_out_next  = vis_out_reg;
        stat_out_next = stat_out_reg;
        rem_start     = 1'b0;
        cell_cmd.op       = CELL_HOLD;
        cell_cmd.row      = row_in_reg[ROW_IDX_W-1:0];
        cell_cmd.pixel_on = on_reg;
        cell_cmd.amount   = steps_reg[ROW_IDX_W-1:0];

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                pix_next    = 1'b0;
                status_next = STAT_OK;
                state_next  = ST_DONE;
                case (op_reg)
                    OP_SET_PIXEL: begin
                        if (row_bad) begin
                            status_next = STAT_ROW_RANGE;
                        end else if (pix_pos >= MAX_SUM) begin
                            status_next = STAT_CAPACITY;
                        end else begin
                            cell_cmd.op = CELL_WRITE;
                            if (pix_pos >= SUM_W'(total_reg)) begin
                                total_next = CNT_W'(pix_pos + SUM_W'(1));
                            end
                        end
                    end
                    OP_GET_PIXEL: begin
                        if (row_bad) begin
                            status_next = STAT_ROW_RANGE;
                        end else if (pix_pos < SUM_W'(total_reg)) begin
                            cell_cmd.op = CELL_LOAD;
                            cnt_next    = pix_pos[IDX_W-1:0];
                            state_next  = ST_READ;
                        end
                    end
                    OP_SET_WIDTH: begin
                        if (wreq_pos > MAX_SUM) begin
                            status_next = STAT_CAPACITY;
                        end else if (wreq_pos > SUM_W'(total_reg)) begin
                            total_next = CNT_W'(wreq_pos);
                        end
                    end
                    OP_CLEAR: begin
                        cell_cmd.op = CELL_CLEAR;
                        total_next  = '0;
                        origin_next = '0;
                    end
                    OP_RESET: begin
                        cell_cmd.op = CELL_CLEAR;
                        origin_next = '0;
                    end
                    OP_ROTATE: begin
                        if ((dir_reg == DIR_RIGHT) || (dir_reg == DIR_LEFT)) begin
                            if ((steps_reg != '0) && (total_reg != '0)) begin
                                rem_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end else if (steps_reg >= STEP_COUNT_W'(ROWS)) begin
                            cell_cmd.op = CELL_CLEAR;
                        end else begin
                            cell_cmd.op = (dir_reg == DIR_UP) ? CELL_UP : CELL_DOWN;
                        end
                    end
                    OP_SHIFT: begin
                        if (total_reg == '0) begin
                            status_next = STAT_EMPTY;
                        end else if (dir_reg == DIR_RIGHT) begin
                            if (steps_w <= origin_w) begin
                                origin_next = CNT_W'(origin_w - steps_w);
                            end else if ((total_w + ins_w) > MAX_WIDE) begin
                                status_next = STAT_CAPACITY;
                            end else begin
                                origin_next = '0;
                                total_next  = CNT_W'(total_w + ins_w);
                                cnt_next    = ins_w[IDX_W-1:0];
                                state_next  = ST_INS;
                            end
                        end else if (left_sum > total_w) begin
                            origin_next = total_reg;
                        end else begin
                            origin_next = CNT_W'(left_sum);
                        end
                    end
                    default: ;
                endcase
            end
            ST_READ: begin
                if (cnt_reg == '0) begin
                    pix_next   = read_bits[0];
                    state_next = ST_DONE;
                end else begin
                    cell_cmd.op = CELL_SHIFT_OUT;
                    cnt_next    = cnt_reg - IDX_W'(1);
                end
            end
            ST_DIV: begin
                if (rem_done) begin
                    if (rot_cnt == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        cnt_next   = rot_cnt[IDX_W-1:0];
                        state_next = ST_ROT;
                    end
                end
            end
            ST_ROT, ST_INS: begin
                cell_cmd.op = (state_reg == ST_ROT) ? CELL_ROTL : CELL_INSR;
                cnt_next    = cnt_reg - IDX_W'(1);
                if (cnt_reg == IDX_W'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    pix_out_next  = pix_reg;
                    vis_out_next  = VISIBLE_WIDTH_W'(vis_full);
                    stat_out_next = status_reg;
                    state_next    = s_tvalid ? ST_EXEC : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            total_reg    <= '0;
            origin_reg   <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            origin_reg   <= origin_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg      <= pix_next;
        status_reg   <= status_next;
        pix_out_reg  <= pix_out_next;
        vis_out_reg  <= vis_out_next;
        stat_out_reg <= stat_out_next;
        if (accept) begin
            op_reg     <= op_t'(s_tuser[OPERATION_W-1:0]);
            col_in_reg <= s_tdata[COLUMN_LSB +: COLUMN_W];
            row_in_reg <= s_tdata[ROW_LSB +: ROW_W];
            on_reg     <= s_tdata[PIXEL_ON_LSB];
            dir_reg    <= dir_t'(s_tdata[DIRECTION_LSB +: DIRECTION_W]);
            steps_reg  <= s_tdata[STEP_COUNT_LSB +: STEP_COUNT_W];
            wreq_reg   <= s_tdata[WIDTH_REQUEST_LSB +: WIDTH_REQUEST_W];
        end
    end

    lcsb_rem #(
        .DVD_W (STEP_COUNT_W),
        .DVS_W (CNT_W)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (steps_reg),
        .divisor   (total_reg),
        .done      (rem_done),
        .remainder (rem_value)
    );

    for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_cell
        logic [ROWS-1:0] next_col;
        logic [ROWS-1:0] prev_col;
        logic            read_in;

        if (i == MAX_COLUMNS - 1) begin : g_tail
            assign next_col = '0;
            assign read_in  = 1'b0;
        end else begin : g_body
            assign next_col = col_data[i+1];
            assign read_in  = read_bits[i+1];
        end

        if (i == 0) begin : g_head
            assign prev_col = '0;
        end else begin : g_rest
            assign prev_col = col_data[i-1];
        end

        lcsb_cell #(
            .IDX   (i),
            .IDX_W (IDX_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cell_cmd),
            .pos      (pix_pos[IDX_W-1:0]),
            .last_idx (last_w[IDX_W-1:0]),
            .next_col (next_col),
            .prev_col (prev_col),
            .head_col (col_data[0]),
            .read_in  (read_in),
            .col      (col_data[i]),
            .read_bit (read_bits[i])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({vis_out_reg, pix_out_reg});
    assign m_tuser  = stat_out_reg;

    a_origin_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        origin_reg <= total_reg)
        else $error("View origin is beyond the stored column count.");

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= MAX_CNT)
        else $error("Stored column count exceeds the capacity.");

    a_rem_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_done |-> (state_reg == ST_DIV))
        else $error("Remainder finished outside a column rotation.");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("Accepted transfer was not executed in the next cycle.");

endmodule

`default_nettype wire
